FILE: src/ort_pkg.sv
// ============================================================================
// ort_pkg: shared types and codes of the ordered record table
// Record layout, command codes, status codes and default table size.
// ============================================================================
`default_nettype none

package ort_pkg;

  // Default number of records the table holds.
  localparam int unsigned TableDepthDefault = 16;

  localparam int unsigned HeadW = 64;
  localparam int unsigned TailW = 8;
  localparam int unsigned KeyW  = HeadW + TailW;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;

  localparam logic [CmdW-1:0] CMD_APPEND = 2'd0;
  localparam logic [CmdW-1:0] CMD_FIND   = 2'd1;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [StatusW-1:0] STAT_ADDED     = 3'd0;
  localparam logic [StatusW-1:0] STAT_FOUND     = 3'd1;
  localparam logic [StatusW-1:0] STAT_DELETED   = 3'd2;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [StatusW-1:0] STAT_FULL      = 3'd4;
  localparam logic [StatusW-1:0] STAT_CLEARED   = 3'd5;

  // One stored record: three 9-byte strings, each as head plus tail byte.
  typedef struct packed {
    logic [HeadW-1:0] name_head;
    logic [TailW-1:0] name_tail;
    logic [HeadW-1:0] surname_head;
    logic [TailW-1:0] surname_tail;
    logic [HeadW-1:0] phone_head;
    logic [TailW-1:0] phone_tail;
  } record_t;

endpackage

`default_nettype wire

FILE: src/ordered_record_table_core.sv
// ============================================================================
// ordered_record_table_core: insertion-ordered table of name records
// Appends, finds by surname, deletes by phone and clears, one command a beat.
// ============================================================================
// Each command beat (in_valid_i / in_ready_o) yields one result beat
// (out_valid_o / out_ready_i): a status code and, for a successful find, the
// full matching record. Append and clear finish in the cycle the command is
// taken; their result passes through the S_DONE state into the output
// register. Find and delete walk the record memory through its one
// registered read port, record by record (S_RD presents the address, then
// S_CMP compares on the shared 72-bit comparator); a delete then moves each
// later record down one place (S_SH_RD reads it, then S_SH_WR writes it
// back one slot lower). in_ready_o is high only while the sequencer is
// idle, so a new command is taken only once the previous result has been
// handed to the output register. A stalled receiver holds the result in
// the output register; the next command is still taken, and its result waits
// in the sequencer until that register frees up, so no beat is lost.
// Reset empties the table and drops any pending result. The record memory
// is not cleared: only entries below the record count are ever used.
`default_nettype none

module ordered_record_table_core #(
  parameter int unsigned TABLE_DEPTH = ort_pkg::TableDepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ort_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [ort_pkg::HeadW-1:0]    name_head_i,
  input  wire logic [ort_pkg::TailW-1:0]    name_tail_i,
  input  wire logic [ort_pkg::HeadW-1:0]    surname_head_i,
  input  wire logic [ort_pkg::TailW-1:0]    surname_tail_i,
  input  wire logic [ort_pkg::HeadW-1:0]    phone_head_i,
  input  wire logic [ort_pkg::TailW-1:0]    phone_tail_i,

  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ort_pkg::StatusW-1:0]       status_o,
  output logic [ort_pkg::HeadW-1:0]         found_name_head_o,
  output logic [ort_pkg::TailW-1:0]         found_name_tail_o,
  output logic [ort_pkg::HeadW-1:0]         found_surname_head_o,
  output logic [ort_pkg::TailW-1:0]         found_surname_tail_o,
  output logic [ort_pkg::HeadW-1:0]         found_phone_head_o,
  output logic [ort_pkg::TailW-1:0]         found_phone_tail_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command
  localparam logic [2:0] S_RD    = 3'd1;  // scan: present address
  localparam logic [2:0] S_CMP   = 3'd2;  // scan: compare read data
  localparam logic [2:0] S_SH_RD = 3'd3;  // close-up: read next record
  localparam logic [2:0] S_SH_WR = 3'd4;  // close-up: write it one slot lower
  localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

  logic [2:0]                     state_q, state_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic                           is_find_q, is_find_d;
  logic [ort_pkg::KeyW-1:0]       key_q, key_d;
  logic [ort_pkg::StatusW-1:0]    res_status_q, res_status_d;
  ort_pkg::record_t               res_rec_q, res_rec_d;

  logic                           out_valid_q, out_valid_d;
  logic [ort_pkg::StatusW-1:0]    out_status_q, out_status_d;
  ort_pkg::record_t               out_rec_q, out_rec_d;

  // Record memory: one write port, one registered read port.
  ort_pkg::record_t               mem [TABLE_DEPTH];
  ort_pkg::record_t               rd_data_q;
  logic                           mem_we;
  logic [IdxW-1:0]                mem_waddr;
  ort_pkg::record_t               mem_wdata;
  logic [IdxW-1:0]                mem_raddr;

  ort_pkg::record_t               in_rec;
  logic                           in_fire;
  logic                           out_free;
  logic [CntW-1:0]                idx_ext;
  logic [CntW-1:0]                idx_inc;
  logic [ort_pkg::KeyW-1:0]       cmp_field;
  logic                           cmp_match;

  assign in_rec = '{
    name_head:    name_head_i,
    name_tail:    name_tail_i,
    surname_head: surname_head_i,
    surname_tail: surname_tail_i,
    phone_head:   phone_head_i,
    phone_tail:   phone_tail_i
  };

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign idx_ext = CntW'(idx_q);
  assign idx_inc = idx_ext + CntOne;

  // The one shared comparator: surname for a find, phone for a delete.
  assign cmp_field = is_find_q ? {rd_data_q.surname_head, rd_data_q.surname_tail}
                               : {rd_data_q.phone_head, rd_data_q.phone_tail};
  assign cmp_match = (cmp_field == key_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    is_find_d    = is_find_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_data_q;
    mem_raddr    = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_rec_d = '0;
          idx_d     = '0;
          is_find_d = (cmd_i == ort_pkg::CMD_FIND);
          key_d     = (cmd_i == ort_pkg::CMD_FIND) ? {surname_head_i, surname_tail_i}
                                                   : {phone_head_i, phone_tail_i};
          unique case (cmd_i)
            ort_pkg::CMD_APPEND: begin
              if (cnt_q == CntFull) begin
                res_status_d = ort_pkg::STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = cnt_q[IdxW-1:0];
                mem_wdata    = in_rec;
                cnt_d        = cnt_q + CntOne;
                res_status_d = ort_pkg::STAT_ADDED;
              end
              state_d = S_DONE;
            end
            ort_pkg::CMD_FIND,
            ort_pkg::CMD_DELETE: begin
              if (cnt_q == '0) begin
                res_status_d = ort_pkg::STAT_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            ort_pkg::CMD_CLEAR: begin
              cnt_d        = '0;
              res_status_d = ort_pkg::STAT_CLEARED;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        mem_raddr = idx_q;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (cmp_match) begin
          if (is_find_q) begin
            res_status_d = ort_pkg::STAT_FOUND;
            res_rec_d    = rd_data_q;
            state_d      = S_DONE;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (idx_inc == cnt_q) begin
          res_status_d = ort_pkg::STAT_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          idx_d   = idx_inc[IdxW-1:0];
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        // Records above the deleted slot move down until the last one has.
        if (idx_inc >= cnt_q) begin
          cnt_d        = cnt_q - CntOne;
          res_status_d = ort_pkg::STAT_DELETED;
          state_d      = S_DONE;
        end else begin
          mem_raddr = idx_inc[IdxW-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = idx_inc[IdxW-1:0];
        state_d   = S_SH_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the sequencer, held while the receiver stalls.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_rec_d    = out_rec_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_rec_d    = res_rec_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    is_find_q    <= is_find_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    out_status_q <= out_status_d;
    out_rec_q    <= out_rec_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign found_name_head_o    = out_rec_q.name_head;
  assign found_name_tail_o    = out_rec_q.name_tail;
  assign found_surname_head_o = out_rec_q.surname_head;
  assign found_surname_tail_o = out_rec_q.surname_tail;
  assign found_phone_head_o   = out_rec_q.phone_head;
  assign found_phone_tail_o   = out_rec_q.phone_tail;

endmodule

`default_nettype wire
